/* hw/rtl/bhoc_pkg.sv */
// Package for the banded heater on/off controller.
// Holds field widths, band and LED codes, register indexes and the reference scaling.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bhoc_pkg;

  localparam int unsigned SampleW = 12;
  localparam int unsigned WordW   = 16;
  localparam int unsigned TempW   = 9;
  localparam int unsigned RefW    = 6;
  localparam int unsigned CmpW    = 16;
  localparam int unsigned MarginW = 5;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  // floor(sample*5/341) == (sample * 5 * 24601) >> 23 for every 12-bit sample
  localparam int unsigned RefProdW = 29;
  localparam int unsigned RefShift = 23;
  localparam logic [RefProdW-1:0] RefMul = RefProdW'(5 * 24601);

  localparam logic [RefW-1:0]    LowBandRst  = RefW'(30);
  localparam logic [RefW-1:0]    MedBandRst  = RefW'(40);
  localparam logic [RefW-1:0]    HighBandRst = RefW'(50);
  localparam logic [CmpW-1:0]    HeatOffRst  = CmpW'(50000);
  localparam logic [MarginW-1:0] MarginRst   = MarginW'(5);

  typedef enum logic [1:0] {
    BandOff  = 2'd0,
    BandLow  = 2'd1,
    BandMed  = 2'd2,
    BandHigh = 2'd3
  } band_e;

  typedef enum logic [1:0] {
    LedNone   = 2'd0,
    LedGreen  = 2'd1,
    LedYellow = 2'd2,
    LedRed    = 2'd3
  } led_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgLowBand  = 3'd0,
    CfgMedBand  = 3'd1,
    CfgHighBand = 3'd2,
    CfgHeatOff  = 3'd3,
    CfgMargin   = 3'd4
  } cfg_idx_e;

endpackage

`default_nettype wire

/* hw/rtl/banded_heater_onoff_controller_top.sv */
// Top level of the banded heater on/off controller.
// Input register, one pass of band control logic, result register. Uses bhoc_pkg.
//
//  channel | direction | handshake                 | payload
//  in      | sink      | in_valid_i / in_stall_o   | setpoint_sample, sensor_word, sensor_fresh
//  out     | source    | out_valid_o / out_stall_i | band_mode .. reference_degrees
//  cfg     | sink      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One beat per cycle sustained while out_stall_i is low; an accepted beat waits in the input register.
// The pass logic (one 12x17 constant multiply plus compares) updates the band state
// as the beat moves from the input register to the result register.
// Reset clears band state, steady flag, held temperature and overshoot LED, and loads
// the register defaults.
// Output stall backs up through both registers; the config port is always ready.
`timescale 1ns / 1ps
`default_nettype none

module banded_heater_onoff_controller_top (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  wire  [bhoc_pkg::SampleW-1:0]  setpoint_sample_i,
  input  wire  [bhoc_pkg::WordW-1:0]    sensor_word_i,
  input  wire                           sensor_fresh_i,
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output logic [1:0]                    band_mode_o,
  output logic [bhoc_pkg::CmpW-1:0]     heater_compare_o,
  output logic [1:0]                    reference_led_o,
  output logic [1:0]                    overshoot_led_o,
  output logic [bhoc_pkg::TempW-1:0]    temperature_half_o,
  output logic [bhoc_pkg::RefW-1:0]     reference_degrees_o,
  input  wire                           cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire  [bhoc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire  [bhoc_pkg::CfgDataW-1:0] cfg_data_i
);
  import bhoc_pkg::*;

  logic [RefW-1:0]    low_band_q, med_band_q, high_band_q;
  logic [CmpW-1:0]    heat_off_q;
  logic [MarginW-1:0] margin_q;

  logic               s1_valid_q;
  logic [SampleW-1:0] s1_sample_q;
  logic [WordW-1:0]   s1_word_q;
  logic               s1_fresh_q;

  band_e              band_q, band_d;
  logic               steady_q, steady_d;
  logic [TempW-1:0]   temp_q, temp_d;
  led_e               ovs_q, ovs_d;

  logic               out_valid_q;
  band_e              out_band_q;
  logic [CmpW-1:0]    out_cmp_q, cmp_d;
  led_e               out_ovs_q;
  logic [TempW-1:0]   out_temp_q;
  logic [RefW-1:0]    out_ref_q;

  logic               out_free, s2_fire, s1_load;
  logic [RefProdW-1:0] ref_prod;
  logic [RefW-1:0]    ref_w;
  logic [RefW:0]      r_w;
  logic signed [10:0] d_w, heat_lim;
  logic signed [15:0] d_ext, d25, d5, ref_ext;
  logic               heat_band, steady_set;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_band_q  <= LowBandRst;
      med_band_q  <= MedBandRst;
      high_band_q <= HighBandRst;
      heat_off_q  <= HeatOffRst;
      margin_q    <= MarginRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgLowBand:  low_band_q  <= cfg_data_i[RefW-1:0];
        CfgMedBand:  med_band_q  <= cfg_data_i[RefW-1:0];
        CfgHighBand: high_band_q <= cfg_data_i[RefW-1:0];
        CfgHeatOff:  heat_off_q  <= cfg_data_i[CmpW-1:0];
        CfgMargin:   margin_q    <= cfg_data_i[MarginW-1:0];
        default: ;
      endcase
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s2_fire    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign s1_load    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load) begin
      s1_valid_q <= 1'b1;
    end else if (s2_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_sample_q <= setpoint_sample_i;
      s1_word_q   <= sensor_word_i;
      s1_fresh_q  <= sensor_fresh_i;
    end
  end

  assign ref_prod = RefProdW'(s1_sample_q) * RefMul;
  assign ref_w    = ref_prod[RefShift +: RefW];
  assign r_w      = {ref_w, 1'b0};
  assign temp_d   = s1_fresh_q ? s1_word_q[WordW-1 -: TempW] : temp_q;
  assign d_w      = $signed({2'b00, temp_d}) - $signed({4'b0000, r_w});
  assign d_ext    = {{5{d_w[10]}}, d_w};
  assign d25      = (d_ext <<< 4) + (d_ext <<< 3) + d_ext;
  assign d5       = (d_ext <<< 2) + d_ext;
  assign ref_ext  = {10'b0, ref_w};
  assign heat_lim = $signed({4'b0000, r_w}) - $signed({6'b000000, margin_q});
  assign steady_set = (temp_d == ({2'b00, r_w} + TempW'(1)));

  always_comb begin
    band_d    = band_q;
    steady_d  = steady_q;
    ovs_d     = ovs_q;
    cmp_d     = heat_off_q;
    heat_band = 1'b0;
    if (band_q == BandOff) begin
      ovs_d = LedNone;
      if (ref_w >= low_band_q) begin
        steady_d = 1'b0;
        band_d   = BandLow;
      end
    end else begin
      if (band_q == BandHigh) begin
        heat_band = ({2'b00, r_w} >= temp_d);
      end else begin
        heat_band = (heat_lim >= $signed({2'b00, temp_d}));
      end
      if (heat_band) begin
        cmp_d = '0;
      end
      if (steady_set) begin
        steady_d = 1'b1;
      end
      if (steady_d && ({2'b00, r_w} > temp_d)) begin
        cmp_d = '0;
      end
      if (steady_d && ({2'b00, r_w} < temp_d)) begin
        cmp_d = heat_off_q;
      end
      if (!d_w[10]) begin
        if (d25 <= ref_ext) begin
          ovs_d = LedGreen;
        end else if (d5 <= ref_ext) begin
          ovs_d = LedYellow;
        end else begin
          ovs_d = LedRed;
        end
      end
      case (band_q)
        BandLow: begin
          if (ref_w >= med_band_q) begin
            steady_d = 1'b0;
            band_d   = BandMed;
          end else if (ref_w < low_band_q) begin
            steady_d = 1'b0;
            band_d   = BandOff;
          end
        end
        BandMed: begin
          if (ref_w >= high_band_q) begin
            steady_d = 1'b0;
            band_d   = BandHigh;
          end else if (ref_w < med_band_q) begin
            steady_d = 1'b0;
            band_d   = BandLow;
          end
        end
        default: begin
          if (ref_w < high_band_q) begin
            steady_d = 1'b0;
            band_d   = BandMed;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_q   <= BandOff;
      steady_q <= 1'b0;
      temp_q   <= '0;
      ovs_q    <= LedNone;
    end else if (s2_fire) begin
      band_q   <= band_d;
      steady_q <= steady_d;
      temp_q   <= temp_d;
      ovs_q    <= ovs_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      out_band_q <= band_q;
      out_cmp_q  <= cmp_d;
      out_ovs_q  <= ovs_d;
      out_temp_q <= temp_d;
      out_ref_q  <= ref_w;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign band_mode_o         = out_band_q;
  assign reference_led_o     = out_band_q;
  assign heater_compare_o    = out_cmp_q;
  assign overshoot_led_o     = out_ovs_q;
  assign temperature_half_o  = out_temp_q;
  assign reference_degrees_o = out_ref_q;

  a_band_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_fire |=> (band_q == $past(band_q) || band_q == $past(band_q) + 2'd1 ||
                 band_q == $past(band_q) - 2'd1))
    else $error("band moved by more than one step");

  a_off_no_overshoot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && band_mode_o == BandOff) |-> (overshoot_led_o == LedNone))
    else $error("overshoot LED lit in off band");

  a_compare_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (heater_compare_o == '0 || heater_compare_o == heat_off_q))
    else $error("heater compare is neither full heat nor off");

  a_empty_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> !in_stall_o)
    else $error("input stalled with empty input register");

endmodule

`default_nettype wire
